>>> rtl/sird_pkg.sv
package sird_pkg;

	localparam int unsigned MAG_W = 63;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned RADIX_W = 6;
	localparam int unsigned DIGIT_W = 6;
	localparam int unsigned CHAR_W = 7;

	localparam int unsigned DIGIT_DEPTH_DEF = 64;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;

	localparam logic [CHAR_W-1:0] CODE_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CODE_MINUS = 7'd45;

	localparam int unsigned DIV_W = 64;
	localparam int unsigned DIV_BITS = 8;
	localparam int unsigned DIV_STEPS = DIV_W / DIV_BITS;

	localparam int unsigned QUEUE_DEPTH = 2;

	typedef struct packed {
		logic             neg;
		logic [MAG_W-1:0] mag;
	} req_t;

endpackage

>>> rtl/signed_integer_to_radix_digits_core.sv
// channel   direction  handshake                  payload
// in        request    in_valid / in_stall        value[63:0] signed
// out       result     out_valid / out_stall      char_code[6:0], last_char
// cfg       write      cfg_we                     cfg_wdata[5:0] (radix)
//
// A request passes these steps in order: the idle state takes it, the divider makes each
// digit (eight quotient bits a cycle over a 64-bit dividend), the sign state sends any
// minus sign, and each character is put out via the registered store read.
// A two-entry queue parts the front from the divider, so requests are taken while another
// converts. Reset clears control only; the digit store needs no clearing.
// Stalls on out hold the output register and the back part; a full queue then stalls in.
module signed_integer_to_radix_digits_core #(
	parameter int unsigned DIGIT_DEPTH = sird_pkg::DIGIT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sird_pkg::VALUE_W-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sird_pkg::CHAR_W-1:0]   char_code,
	output logic                          last_char,
	input  logic                          cfg_we,
	input  logic [sird_pkg::RADIX_W-1:0]  cfg_wdata
);

	logic [sird_pkg::RADIX_W-1:0]  radix_q;
	logic                          front_valid;
	logic                          q_full;
	logic                          q_not_empty;
	logic                          q_pop;
	sird_pkg::req_t                front_req;
	sird_pkg::req_t                q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= sird_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	sird_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.req_valid (front_valid),
		.req_full  (q_full),
		.req       (front_req)
	);

	sird_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_req),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	sird_back #(
		.DIGIT_DEPTH (DIGIT_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.radix     (radix_q),
		.req_avail (q_not_empty),
		.req       (q_head),
		.req_take  (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char)
	);

endmodule

>>> rtl/sird_front.sv
module sird_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sird_pkg::VALUE_W-1:0]  value,
	output logic                          req_valid,
	input  logic                          req_full,
	output sird_pkg::req_t                req
);

	logic                          valid_q;
	sird_pkg::req_t                req_q;
	logic                          accept;
	logic [sird_pkg::VALUE_W-1:0]  abs_v;
	sird_pkg::req_t                req_d;

	assign in_stall = valid_q & req_full;
	assign accept = in_valid & ~in_stall;

	always_comb begin
		abs_v = value[sird_pkg::VALUE_W-1] ? (~value + 64'd1) : value;
		req_d.neg = value[sird_pkg::VALUE_W-1];
		if (abs_v[sird_pkg::VALUE_W-1]) begin
			req_d.mag = '1;
		end else begin
			req_d.mag = abs_v[sird_pkg::MAG_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= accept | (valid_q & req_full);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_d;
		end
	end

	assign req_valid = valid_q;
	assign req = req_q;

endmodule

>>> rtl/sird_queue.sv
module sird_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  sird_pkg::req_t  push_data,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output sird_pkg::req_t  head
);

	localparam int unsigned PW = $clog2(sird_pkg::QUEUE_DEPTH);
	localparam int unsigned NW = $clog2(sird_pkg::QUEUE_DEPTH + 1);

	sird_pkg::req_t  entry_q [sird_pkg::QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [NW-1:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign full = (fill_q == NW'(sird_pkg::QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign do_push = push & ~full;
	assign do_pop = pop & not_empty;
	assign head = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(sird_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(sird_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> rtl/sird_back.sv
module sird_back #(
	parameter int unsigned DIGIT_DEPTH = sird_pkg::DIGIT_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sird_pkg::RADIX_W-1:0]  radix,
	input  logic                          req_avail,
	input  sird_pkg::req_t                req,
	output logic                          req_take,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sird_pkg::CHAR_W-1:0]   char_code,
	output logic                          last_char
);

	localparam int unsigned AW = $clog2(DIGIT_DEPTH);
	localparam int unsigned CW = $clog2(DIGIT_DEPTH + 1);
	localparam int unsigned SW = $clog2(sird_pkg::DIV_STEPS);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_SIGN = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_PUT  = 3'd4;

	logic [sird_pkg::DIGIT_W-1:0]  digit_mem [DIGIT_DEPTH];
	logic [sird_pkg::DIGIT_W-1:0]  rdata_q;

	logic [2:0]                    state_q;
	logic [sird_pkg::DIV_W-1:0]    work_q;
	logic [sird_pkg::DIGIT_W-1:0]  rem_q;
	logic [SW-1:0]                 step_q;
	logic [CW-1:0]                 cnt_q;
	logic                          neg_q;

	logic                          out_valid_q;
	logic [sird_pkg::CHAR_W-1:0]   char_q;
	logic                          last_q;

	logic [sird_pkg::RADIX_W-1:0]  r_eff;
	logic [sird_pkg::DIGIT_W-1:0]  rem_n;
	logic [sird_pkg::DIV_BITS-1:0] qbits;
	logic [sird_pkg::DIV_W-1:0]    work_n;
	logic                          out_free;
	logic                          out_set;
	logic                          mem_we;
	logic                          mem_re;
	logic [AW-1:0]                 rd_addr;

	always_comb begin
		if (radix < sird_pkg::RADIX_MIN) begin
			r_eff = sird_pkg::RADIX_MIN;
		end else if (radix > sird_pkg::RADIX_MAX) begin
			r_eff = sird_pkg::RADIX_MAX;
		end else begin
			r_eff = radix;
		end
	end

	always_comb begin
		logic [sird_pkg::DIGIT_W:0] t;
		rem_n = rem_q;
		qbits = '0;
		t = '0;
		for (int i = 0; i < sird_pkg::DIV_BITS; i++) begin
			t = {rem_n, work_q[sird_pkg::DIV_W-1-i]};
			if (t >= {1'b0, r_eff}) begin
				t = t - {1'b0, r_eff};
				qbits[sird_pkg::DIV_BITS-1-i] = 1'b1;
			end
			rem_n = t[sird_pkg::DIGIT_W-1:0];
		end
		work_n = {work_q[sird_pkg::DIV_W-sird_pkg::DIV_BITS-1:0], qbits};
	end

	assign out_free = ~out_valid_q | ~out_stall;
	assign out_set = (((state_q == ST_SIGN) & neg_q) | (state_q == ST_PUT)) & out_free;
	assign req_take = (state_q == ST_IDLE) & req_avail;
	assign mem_we = (state_q == ST_DIV) & (step_q == SW'(sird_pkg::DIV_STEPS - 1));
	assign mem_re = (state_q == ST_READ);
	assign rd_addr = AW'(cnt_q - 1'b1);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			digit_mem[cnt_q[AW-1:0]] <= rem_n;
		end
		if (mem_re) begin
			rdata_q <= digit_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			step_q <= '0;
		end else begin
			out_valid_q <= out_set | (out_valid_q & out_stall);
			case (state_q)
				ST_IDLE: begin
					if (req_avail) begin
						cnt_q <= '0;
						step_q <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == SW'(sird_pkg::DIV_STEPS - 1)) begin
						cnt_q <= cnt_q + 1'b1;
						if (work_n == '0 || cnt_q == CW'(DIGIT_DEPTH - 1)) begin
							state_q <= ST_SIGN;
						end
					end
				end
				ST_SIGN: begin
					if (!neg_q || out_free) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_PUT;
				end
				ST_PUT: begin
					if (out_free) begin
						cnt_q <= cnt_q - 1'b1;
						state_q <= (cnt_q == CW'(1)) ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_avail) begin
					work_q <= {1'b0, req.mag};
					rem_q <= '0;
					neg_q <= req.neg;
				end
			end
			ST_DIV: begin
				if (step_q == SW'(sird_pkg::DIV_STEPS - 1)) begin
					work_q <= work_n;
					rem_q <= '0;
				end else begin
					work_q <= work_n;
					rem_q <= rem_n;
				end
			end
			ST_SIGN: begin
				if (neg_q && out_free) begin
					char_q <= sird_pkg::CODE_MINUS;
					last_q <= 1'b0;
				end
			end
			ST_PUT: begin
				if (out_free) begin
					char_q <= sird_pkg::CODE_ZERO + {1'b0, rdata_q};
					last_q <= (cnt_q == CW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign char_code = char_q;
	assign last_char = last_q;

endmodule

>>> test/signed_integer_to_radix_digits_core_tb.sv
`timescale 1ns / 1ps

module signed_integer_to_radix_digits_core_tb;

	localparam int unsigned CYCLE_LIMIT = 2000000;
	localparam int unsigned SETTLE_CYCLES = 64;
	localparam logic [sird_pkg::VALUE_W-1:0] MAX_POS = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [sird_pkg::VALUE_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;

	typedef struct packed {
		logic [sird_pkg::CHAR_W-1:0] code;
		logic                        last;
	} char_expect_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic [sird_pkg::VALUE_W-1:0]   value = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [sird_pkg::CHAR_W-1:0]    char_code;
	logic                           last_char;
	logic                           cfg_we = 1'b0;
	logic [sird_pkg::RADIX_W-1:0]   cfg_wdata = sird_pkg::RADIX_RESET;

	char_expect_t                   expected_chars[$];
	logic [sird_pkg::RADIX_W-1:0]   radix_copy = sird_pkg::RADIX_RESET;
	int unsigned                    send_idle_pct = 35;
	int unsigned                    recv_stall_pct = 56;
	int unsigned                    errors = 0;
	int unsigned                    cycles = 0;

	signed_integer_to_radix_digits_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code),
		.last_char (last_char),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void predict_chars(input logic [sird_pkg::VALUE_W-1:0] v,
			input logic [sird_pkg::RADIX_W-1:0] rad);
		logic [sird_pkg::VALUE_W-1:0] mag;
		logic [sird_pkg::VALUE_W-1:0] base;
		logic [sird_pkg::DIGIT_W-1:0] digit_buf [sird_pkg::DIGIT_DEPTH_DEF];
		int unsigned                  n;
		base = (rad < sird_pkg::RADIX_MIN) ? sird_pkg::VALUE_W'(sird_pkg::RADIX_MIN) :
			(rad > sird_pkg::RADIX_MAX) ? sird_pkg::VALUE_W'(sird_pkg::RADIX_MAX) :
			sird_pkg::VALUE_W'(rad);
		mag = v[sird_pkg::VALUE_W-1] ? (~v + 1'b1) : v;
		if (mag > MAX_POS)
			mag = MAX_POS;
		n = 0;
		if (mag == '0) begin
			digit_buf[0] = '0;
			n = 1;
		end else begin
			while (mag != '0 && n < sird_pkg::DIGIT_DEPTH_DEF) begin
				digit_buf[n] = sird_pkg::DIGIT_W'(mag % base);
				mag = mag / base;
				n++;
			end
		end
		if (v[sird_pkg::VALUE_W-1])
			expected_chars.push_back('{code: sird_pkg::CODE_MINUS, last: 1'b0});
		for (int i = int'(n); i > 0; i--)
			expected_chars.push_back('{code: sird_pkg::CODE_ZERO +
				sird_pkg::CHAR_W'(digit_buf[i-1]), last: (i == 1)});
	endfunction

	function automatic logic [sird_pkg::VALUE_W-1:0] random_value();
		logic [sird_pkg::VALUE_W-1:0] raw;
		logic [sird_pkg::VALUE_W-1:0] mag;
		int unsigned                  len;
		raw = {$urandom, $urandom};
		if ($urandom_range(3, 0) == 0)
			return (raw == MOST_NEG) ? MAX_POS : raw;
		len = $urandom_range(63, 0);
		mag = (len == 0) ? '0 : (raw >> (sird_pkg::VALUE_W - len));
		return $urandom_range(1, 0) ? (~mag + 1'b1) : mag;
	endfunction

	function automatic logic [sird_pkg::RADIX_W-1:0] random_radix();
		case ($urandom_range(4, 0))
			0: return sird_pkg::RADIX_W'($urandom_range(1, 0));
			1: return sird_pkg::RADIX_W'($urandom_range(63, 37));
			default: return sird_pkg::RADIX_W'($urandom_range(36, 2));
		endcase
	endfunction

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** signed_integer_to_radix_digits_core: FAILED **");
			$finish;
		end
	end

	always @(posedge clk) begin
		char_expect_t exp_char;
		if (out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected char_code %0d last_char %0b", $time,
					char_code, last_char);
				errors++;
			end else begin
				exp_char = expected_chars.pop_front();
				if (char_code !== exp_char.code) begin
					$display("%0t: char_code expected %0d actual %0d", $time,
						exp_char.code, char_code);
					errors++;
				end
				if (last_char !== exp_char.last) begin
					$display("%0t: last_char expected %0b actual %0b", $time,
						exp_char.last, last_char);
					errors++;
				end
			end
		end
		if (cfg_we)
			radix_copy = cfg_wdata;
		if (in_valid && !in_stall)
			predict_chars(value, radix_copy);
	end

	task automatic send_request(input logic [sird_pkg::VALUE_W-1:0] v);
		while ($urandom_range(99, 0) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_chars.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_radix(input logic [sird_pkg::RADIX_W-1:0] rad);
		cfg_we <= 1'b1;
		cfg_wdata <= rad;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_reset_radix();
		send_request('0);
		send_request(64'd1);
		send_request(-64'sd1);
		send_request(64'd9);
		send_request(64'd10);
		send_request(-64'sd10);
		send_request(MAX_POS);
		send_request(~MAX_POS + 1'b1);
		send_request(64'd1234567890);
		wait_drained();
	endtask

	task automatic test_radix_clamp();
		logic [sird_pkg::RADIX_W-1:0] extremes [6];
		logic [sird_pkg::RADIX_W-1:0] eff;
		extremes = '{6'd0, 6'd1, 6'd2, 6'd36, 6'd37, 6'd63};
		foreach (extremes[i]) begin
			eff = (extremes[i] < sird_pkg::RADIX_MIN) ? sird_pkg::RADIX_MIN :
				(extremes[i] > sird_pkg::RADIX_MAX) ? sird_pkg::RADIX_MAX : extremes[i];
			write_radix(extremes[i]);
			send_request(MAX_POS);
			send_request(-sird_pkg::VALUE_W'(eff - 1'b1));
			wait_drained();
		end
	endtask

	task automatic test_random_values(input int unsigned idle_pct,
			input int unsigned stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (4) begin
			write_radix(random_radix());
			repeat (25) send_request(random_value());
			wait_drained();
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_radix();
		test_radix_clamp();
		test_random_values(35, 56);
		test_random_values(56, 35);
		test_random_values(0, 0);
		write_radix(sird_pkg::RADIX_RESET);
		send_request(random_value());
		wait_drained();
		if (errors == 0) begin
			$display("** signed_integer_to_radix_digits_core: PASSED **");
		end else begin
			$display("** signed_integer_to_radix_digits_core: FAILED **");
		end
		$finish;
	end

endmodule
